/* design/ihp_pkg.sv */
// Shared types and constants for the indexed max-heap.
package ihp_pkg;

    localparam int KEY_W      = 32;
    localparam int HND_W      = 10;
    localparam int POS_W      = 10;
    localparam int CNT_W      = 11;
    localparam int HEAP_DEPTH = 1024;
    localparam int HND_COUNT  = 1024;

    localparam logic [2:0] ACT_INSERT   = 3'd0;
    localparam logic [2:0] ACT_POP_TOP  = 3'd1;
    localparam logic [2:0] ACT_REMOVE   = 3'd2;
    localparam logic [2:0] ACT_INCREASE = 3'd3;
    localparam logic [2:0] ACT_DECREASE = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    typedef struct packed {
        logic [2:0]       action;
        logic [KEY_W-1:0] key;
        logic [HND_W-1:0] handle;
        logic [KEY_W-1:0] delta;
    } ihp_req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [KEY_W-1:0] top_key;
        logic [HND_W-1:0] top_handle;
        logic [CNT_W-1:0] entry_count;
        logic             heap_empty;
        logic             heap_full;
        logic [POS_W-1:0] final_position;
    } ihp_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HND_W-1:0] handle;
    } ihp_entry_t;

endpackage

/* design/ihp_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
module ihp_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/indexed_max_heap.sv */
// Indexed max-heap: one request walks one root-to-leaf path over a shared entry RAM.
// Sift-up reads a parent, then compares; sift-down reads the left child, then the right
// child, then compares, as the entry RAM has one read port. A remove by handle deep in a
// full heap climbs and then sinks a whole path. The next request is taken the cycle after
// the result register loads. Reset clears the count, sets capacity to 1024, then a pass
// over all handles clears the position map and its live flags; heap RAM stays undefined.
module indexed_max_heap (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [10:0]     cfg_wdata,
    input  logic            req_valid,
    output logic            req_stall,
    input  ihp_pkg::ihp_req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ihp_pkg::ihp_rsp_t rsp
);
    import ihp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_APPLY  = 4'd3;
    localparam logic [3:0] S_UP_RD  = 4'd4;
    localparam logic [3:0] S_UP_CMP = 4'd5;
    localparam logic [3:0] S_POP_RD = 4'd6;
    localparam logic [3:0] S_POP    = 4'd7;
    localparam logic [3:0] S_POP_LD = 4'd8;
    localparam logic [3:0] S_DN_L   = 4'd9;
    localparam logic [3:0] S_DN_R   = 4'd10;
    localparam logic [3:0] S_DN_CMP = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_RES    = 4'd13;
    localparam logic [3:0] S_CLR    = 4'd14;

    logic [3:0]       state_reg, state_next;
    ihp_req_t         req_reg;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [KEY_W-1:0] k_reg, k_next;
    logic [HND_W-1:0] h_reg, h_next;
    logic             force_reg, force_next;
    logic             hasr_reg, hasr_next;
    ihp_entry_t       lq_reg, lq_next;
    logic [2:0]       st_reg, st_next;
    logic [HND_W-1:0] clr_reg, clr_next;
    logic             rsp_valid_reg;
    ihp_rsp_t         rsp_reg, rsp_next;
    logic             rsp_load;

    logic             hm_we, hm_re, pm_we, pm_re;
    logic [POS_W-1:0] hm_waddr, hm_raddr;
    logic [HND_W-1:0] pm_waddr, pm_raddr;
    ihp_entry_t       hm_wdata, hm_rdata;
    // position map entry: {live, position}
    logic [POS_W:0]   pm_wdata, pm_rdata;

    logic [CNT_W-1:0] eff_cap;
    logic [POS_W-1:0] par;
    logic [11:0]      c_l, c_r;
    logic [KEY_W:0]   sum;
    logic             pick_r;
    ihp_entry_t       child;
    logic [POS_W-1:0] child_pos;
    logic [CNT_W-1:0] cnt_dec;

    ihp_ram #(.WIDTH($bits(ihp_entry_t)), .DEPTH(HEAP_DEPTH), .AW(POS_W)) u_heap (
        .clk(clk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
        .re(hm_re), .raddr(hm_raddr), .rdata(hm_rdata)
    );

    ihp_ram #(.WIDTH(POS_W + 1), .DEPTH(HND_COUNT), .AW(HND_W)) u_posmap (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .re(pm_re), .raddr(pm_raddr), .rdata(pm_rdata)
    );

    assign eff_cap   = (cap_reg > CNT_W'(HEAP_DEPTH)) ? CNT_W'(HEAP_DEPTH) : cap_reg;
    assign par       = POS_W'((pos_reg - POS_W'(1)) >> 1);
    assign c_l       = {1'b0, pos_reg, 1'b1};
    assign c_r       = c_l + 12'd1;
    assign sum       = {1'b0, hm_rdata.key} + {1'b0, req_reg.delta};
    assign pick_r    = hasr_reg && (lq_reg.key < hm_rdata.key);
    assign child     = pick_r ? hm_rdata : lq_reg;
    assign child_pos = pick_r ? c_r[POS_W-1:0] : c_l[POS_W-1:0];
    assign cnt_dec   = cnt_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        h_next     = h_reg;
        force_next = force_reg;
        hasr_next  = hasr_reg;
        lq_next    = lq_reg;
        st_next    = st_reg;
        clr_next   = clr_reg;
        rsp_next   = rsp_reg;
        rsp_load   = 1'b0;
        hm_we = 1'b0; hm_waddr = pos_reg; hm_wdata = '{key: k_reg, handle: h_reg};
        hm_re = 1'b0; hm_raddr = '0;
        pm_we = 1'b0; pm_waddr = h_reg; pm_wdata = {1'b1, pos_reg};
        pm_re = 1'b0; pm_raddr = req_reg.handle;

        unique case (state_reg)
            S_CLR:
            begin
                pm_we    = 1'b1;
                pm_waddr = clr_reg;
                pm_wdata = '0;
                clr_next = clr_reg + HND_W'(1);
                if (clr_reg == HND_W'(HND_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next    = ST_OK;
                pm_re      = 1'b1;
                state_next = S_FIN;
                case (req_reg.action) inside
                    ACT_POP_TOP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_POP_RD;
                        end
                    end
                    ACT_INSERT, ACT_REMOVE, ACT_INCREASE, ACT_DECREASE:
                    begin
                        state_next = S_LOOK;
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
            S_LOOK:
            begin
                state_next = S_FIN;
                if (req_reg.action == ACT_INSERT)
                begin
                    if (pm_rdata[POS_W])
                    begin
                        st_next = ST_PRESENT;
                    end
                    else if (cnt_reg >= eff_cap)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        // live flag is set when the entry comes to rest
                        pos_next   = cnt_reg[POS_W-1:0];
                        cnt_next   = cnt_reg + CNT_W'(1);
                        k_next     = req_reg.key;
                        h_next     = req_reg.handle;
                        force_next = 1'b0;
                        state_next = S_UP_RD;
                    end
                end
                else if (!pm_rdata[POS_W])
                begin
                    st_next = ST_ABSENT;
                end
                else
                begin
                    pos_next = pm_rdata[POS_W-1:0];
                    h_next   = req_reg.handle;
                    if (req_reg.action == ACT_REMOVE)
                    begin
                        force_next = 1'b1;
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        hm_re      = 1'b1;
                        hm_raddr   = pm_rdata[POS_W-1:0];
                        state_next = S_APPLY;
                    end
                end
            end
            S_APPLY:
            begin
                force_next = 1'b0;
                if (req_reg.action == ACT_INCREASE)
                begin
                    k_next     = (sum[KEY_W] == 1'b0) ? sum[KEY_W-1:0] : '1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    k_next     = (hm_rdata.key > req_reg.delta) ?
                                 hm_rdata.key - req_reg.delta : '0;
                    state_next = S_DN_L;
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    if (force_reg)
                    begin
                        // removed entry sits at the root; pop it
                        state_next = S_POP;
                    end
                    else
                    begin
                        hm_we = 1'b1;
                        pm_we = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    hm_re      = 1'b1;
                    hm_raddr   = par;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (!force_reg && (k_reg <= hm_rdata.key))
                begin
                    hm_we = 1'b1;
                    pm_we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    hm_we    = 1'b1;
                    hm_wdata = hm_rdata;
                    pm_we    = 1'b1;
                    pm_waddr = hm_rdata.handle;
                    pos_next = par;
                    state_next = S_UP_RD;
                end
            end
            S_POP_RD:
            begin
                hm_re      = 1'b1;
                hm_raddr   = '0;
                state_next = S_POP;
            end
            S_POP:
            begin
                pm_we    = 1'b1;
                pm_wdata = '0;
                if (req_reg.action == ACT_POP_TOP)
                begin
                    pm_waddr = hm_rdata.handle;
                end
                else
                begin
                    pm_waddr = req_reg.handle;
                end
                cnt_next = cnt_dec;
                if (cnt_dec != '0)
                begin
                    hm_re      = 1'b1;
                    hm_raddr   = cnt_dec[POS_W-1:0];
                    state_next = S_POP_LD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_POP_LD:
            begin
                k_next     = hm_rdata.key;
                h_next     = hm_rdata.handle;
                pos_next   = '0;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (c_l >= {1'b0, cnt_reg})
                begin
                    hm_we = 1'b1;
                    pm_we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    hm_re      = 1'b1;
                    hm_raddr   = c_l[POS_W-1:0];
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                lq_next    = hm_rdata;
                hasr_next  = c_r < {1'b0, cnt_reg};
                hm_re      = c_r < {1'b0, cnt_reg};
                hm_raddr   = c_r[POS_W-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (k_reg > child.key)
                begin
                    hm_we = 1'b1;
                    pm_we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    hm_we    = 1'b1;
                    hm_wdata = child;
                    pm_we    = 1'b1;
                    pm_waddr = child.handle;
                    pos_next = child_pos;
                    state_next = S_DN_L;
                end
            end
            S_FIN:
            begin
                hm_re      = 1'b1;
                hm_raddr   = '0;
                state_next = S_RES;
            end
            S_RES:
            begin
                rsp_next.status      = st_reg;
                rsp_next.top_key     = (cnt_reg != '0) ? hm_rdata.key : '0;
                rsp_next.top_handle  = (cnt_reg != '0) ? hm_rdata.handle : '0;
                rsp_next.entry_count = cnt_reg;
                rsp_next.heap_empty  = cnt_reg == '0;
                rsp_next.heap_full   = cnt_reg >= eff_cap;
                rsp_next.final_position = ((st_reg == ST_OK) &&
                    ((req_reg.action == ACT_INSERT) || (req_reg.action == ACT_INCREASE) ||
                     (req_reg.action == ACT_DECREASE))) ? pos_reg : '0;
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cap_reg       <= CNT_W'(1024);
            cnt_reg       <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            pos_reg       <= '0;
            force_reg     <= 1'b0;
            hasr_reg      <= 1'b0;
            st_reg        <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            pos_reg   <= pos_next;
            force_reg <= force_next;
            hasr_reg  <= hasr_next;
            st_reg    <= st_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            req_reg <= req;
        end
        k_reg  <= k_next;
        h_reg  <= h_next;
        lq_reg <= lq_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_DEC))
        else $error("accepted request not decoded");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.heap_empty) |-> (rsp.top_key == '0 && rsp.entry_count == '0))
        else $error("empty heap reports a top entry");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> (state_reg == S_IDLE && rsp_valid))
        else $error("result load did not return to idle");

endmodule
